### sv/psc_pkg.sv
// shared types, constants and register indexes of the pi motor speed controller
// no dependencies
package psc_pkg;

  // edge counter width default
  localparam int CounterBitsDefault = 15;

  // depth of the internal and result queues
  localparam int FifoDepth = 2;

  // configuration port
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;

  localparam logic [CfgIdxBits-1:0] RegReferenceRpm  = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegPropGain      = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegIntGainDt     = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegIntegralLimit = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegDutyMax       = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegRpmPerCount   = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegFineTuneSpan  = 3'd6;

  // register reset values
  localparam logic [15:0] ReferenceRpmRst  = 16'd0;
  localparam logic [15:0] PropGainRst      = 16'd3277;
  localparam logic [15:0] IntGainDtRst     = 16'd983;
  localparam logic [9:0]  IntegralLimitRst = 10'd166;
  localparam logic [9:0]  DutyMaxRst       = 10'd249;
  localparam logic [15:0] RpmPerCountRst   = 16'd16000;
  localparam logic [15:0] FineTuneSpanRst  = 16'd1280;

  // adc midpoint, the zero of the fine-tune offset
  localparam logic [10:0] AdcMid = 11'd512;

  typedef struct packed {
    logic [15:0] reference_rpm;
    logic [15:0] prop_gain;
    logic [15:0] int_gain_dt;
    logic [9:0]  integral_limit;
    logic [9:0]  duty_max;
    logic [15:0] rpm_per_count;
    logic [15:0] fine_tune_span;
  } cfg_t;

  typedef struct packed {
    logic [9:0]  duty;
    logic [23:0] measured_rpm;
    logic        integral_clamped;
    logic        output_clamped;
  } result_t;

endpackage

### sv/psc_fifo.sv
// small register queue used between the parts of the speed controller
// depends on psc_pkg for its depth
module psc_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);

  localparam int PtrBits = (psc_pkg::FifoDepth > 1) ? $clog2(psc_pkg::FifoDepth) : 1;
  localparam int CntBits = $clog2(psc_pkg::FifoDepth + 1);
  localparam logic [CntBits-1:0] DepthC = CntBits'(psc_pkg::FifoDepth);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(psc_pkg::FifoDepth - 1);

  logic [Width-1:0]   mem_q [psc_pkg::FifoDepth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == DepthC);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### sv/psc_front.sv
// front part: takes input words, counts encoder edges, queues control ticks
// depends on psc_pkg and psc_fifo
module psc_front #(
  parameter int CounterBits = psc_pkg::CounterBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic                   action_i,
  input  logic [9:0]             adc_sample_i,
  output logic                   full_o,
  input  logic                   tick_pop_i,
  output logic                   tick_valid_o,
  output logic [CounterBits-1:0] tick_cnt_o,
  output logic [9:0]             tick_adc_o
);

  localparam int TickBits = CounterBits + 10;

  logic [CounterBits-1:0] cnt_q, cnt_d;
  logic                   accept, tick_push, tick_full, tick_empty;
  logic [TickBits-1:0]    tick_wdata, tick_rdata;

  assign full_o     = tick_full;
  assign accept     = push_i & ~tick_full;
  assign tick_push  = accept & action_i;
  assign tick_wdata = {cnt_q, adc_sample_i};

  // edges saturate, a tick snapshots and clears the count
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (action_i) begin
        cnt_d = '0;
      end else if (!(&cnt_q)) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  psc_fifo #(
    .Width(TickBits)
  ) u_tick_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (tick_push),
    .wdata_i(tick_wdata),
    .pop_i  (tick_pop_i),
    .full_o (tick_full),
    .empty_o(tick_empty),
    .rdata_o(tick_rdata)
  );

  assign tick_valid_o = ~tick_empty;
  assign tick_cnt_o   = tick_rdata[TickBits-1:10];
  assign tick_adc_o   = tick_rdata[9:0];

endmodule

### sv/psc_back.sv
// back part: multi-cycle pi step with anti-windup, one control tick at a time
// depends on psc_pkg
module psc_back #(
  parameter int CounterBits = psc_pkg::CounterBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  psc_pkg::cfg_t          cfg_i,
  input  logic                   tick_valid_i,
  input  logic [CounterBits-1:0] tick_cnt_i,
  input  logic [9:0]             tick_adc_i,
  output logic                   tick_pop_o,
  input  logic                   res_full_i,
  output logic                   res_push_o,
  output psc_pkg::result_t       res_o
);

  localparam int SpW = CounterBits + 16;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul1 = 3'd1;
  localparam logic [2:0] StSat  = 3'd2;
  localparam logic [2:0] StErr  = 3'd3;
  localparam logic [2:0] StMul2 = 3'd4;
  localparam logic [2:0] StInt  = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0] state_q, state_d;

  logic [CounterBits-1:0] cnt_q;
  logic [9:0]             adc_q;
  logic [SpW-1:0]         spd_prod_q;
  logic signed [27:0]     offs_prod_q;
  logic [31:0]            speed_q;
  logic [24:0]            refadj_q;
  logic signed [33:0]     err_q;
  logic signed [50:0]     iprod_q, pprod_q;
  logic [25:0]            integ_q, integ_d;
  logic                   int_clamp_q, int_clamp_d;

  logic [47:0]        spd_ext;
  logic [31:0]        speed_sat;
  logic signed [10:0] adc_diff;
  logic signed [27:0] offs_shift;
  logic signed [25:0] refadj_s;
  logic signed [33:0] err_d;
  logic signed [50:0] istep, pterm;
  logic signed [43:0] isum;
  logic [25:0]        lim;
  logic signed [47:0] osum;
  logic [25:0]        dmax;
  logic [25:0]        osum_cl;
  logic               out_clamp;

  // saturate the q.8 speed to 32 bits
  assign spd_ext   = 48'(spd_prod_q);
  assign speed_sat = (|spd_ext[47:32]) ? 32'hFFFF_FFFF : spd_ext[31:0];

  // floor of the scaled potentiometer offset, then the adjusted reference
  assign adc_diff   = $signed({1'b0, adc_q}) - $signed(psc_pkg::AdcMid);
  assign offs_shift = offs_prod_q >>> 9;
  assign refadj_s   = $signed({2'b00, cfg_i.reference_rpm, 8'h00})
                    + $signed(offs_shift[25:0]);

  assign err_d = $signed({9'b0, refadj_q}) - $signed({2'b00, speed_q});

  // integral update with clamp to [0, limit]
  assign istep = iprod_q >>> 8;
  assign isum  = $signed({18'b0, integ_q}) + $signed(istep[43:0]);
  assign lim   = {cfg_i.integral_limit, 16'h0000};

  always_comb begin
    integ_d     = integ_q;
    int_clamp_d = int_clamp_q;
    if (state_q == StInt) begin
      if (isum < 0) begin
        integ_d     = '0;
        int_clamp_d = 1'b1;
      end else if (isum > $signed({18'b0, lim})) begin
        integ_d     = lim;
        int_clamp_d = 1'b1;
      end else begin
        integ_d     = isum[25:0];
        int_clamp_d = 1'b0;
      end
    end
  end

  // pi sum with clamp to [0, duty_max]
  assign pterm = pprod_q >>> 4;
  assign osum  = $signed(pterm[47:0]) + $signed({22'b0, integ_q});
  assign dmax  = {cfg_i.duty_max, 16'h0000};

  always_comb begin
    if (osum < 0) begin
      osum_cl   = '0;
      out_clamp = 1'b1;
    end else if (osum > $signed({22'b0, dmax})) begin
      osum_cl   = dmax;
      out_clamp = 1'b1;
    end else begin
      osum_cl   = osum[25:0];
      out_clamp = 1'b0;
    end
  end

  assign tick_pop_o = (state_q == StIdle) & tick_valid_i;
  assign res_push_o = (state_q == StOut) & ~res_full_i;

  assign res_o.duty             = osum_cl[25:16];
  assign res_o.measured_rpm     = speed_q[31:8];
  assign res_o.integral_clamped = int_clamp_q;
  assign res_o.output_clamped   = out_clamp;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (tick_valid_i) state_d = StMul1;
      StMul1:  state_d = StSat;
      StSat:   state_d = StErr;
      StErr:   state_d = StMul2;
      StMul2:  state_d = StInt;
      StInt:   state_d = StOut;
      StOut:   if (!res_full_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      integ_q     <= '0;
      int_clamp_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      integ_q     <= integ_d;
      int_clamp_q <= int_clamp_d;
    end
  end

  // datapath registers, one step per state
  always_ff @(posedge clk_i) begin
    if (tick_pop_o) begin
      cnt_q <= tick_cnt_i;
      adc_q <= tick_adc_i;
    end
    if (state_q == StMul1) begin
      spd_prod_q  <= SpW'(cnt_q) * SpW'(cfg_i.rpm_per_count);
      offs_prod_q <= 28'(adc_diff) * 28'($signed({1'b0, cfg_i.fine_tune_span}));
    end
    if (state_q == StSat) begin
      speed_q  <= speed_sat;
      refadj_q <= refadj_s[25] ? '0 : refadj_s[24:0];
    end
    if (state_q == StErr) begin
      err_q <= err_d;
    end
    if (state_q == StMul2) begin
      iprod_q <= 51'(err_q) * 51'($signed({1'b0, cfg_i.int_gain_dt}));
      pprod_q <= 51'(err_q) * 51'($signed({1'b0, cfg_i.prop_gain}));
    end
  end

endmodule

### sv/pi_motor_speed_controller.sv
// top level of the pi motor speed controller with anti-windup
// depends on psc_pkg, psc_fifo, psc_front and psc_back
//
// Fixed-point PI speed loop. An input word is either an encoder edge (action 0),
// which bumps a saturating edge counter and yields no result, or a control tick
// (action 1) carrying a potentiometer sample, which yields one result word with
// the new duty, the measured speed in whole RPM and two clamp flags. Edges are
// taken one per cycle while full is low. A tick snapshots and clears the counter
// in the cycle it is taken and goes through a two-word queue to the PI unit,
// which has two multiply stages plus saturation, error, integral clamp and
// output clamp, one step per state, handles one tick at a time; the result then
// waits in a two-word output queue, so full rises only when two ticks are
// already waiting for the PI unit. Write configuration only while no tick is in
// flight. Register indexes: 0 reference_rpm, 1 prop_gain, 2 int_gain_dt,
// 3 integral_limit, 4 duty_max, 5 rpm_per_count, 6 fine_tune_span; index 7 is
// ignored. Register data is taken from the low bits of cfg_data_i.
module pi_motor_speed_controller #(
  parameter int CounterBits = psc_pkg::CounterBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input queue side
  input  logic                            push,
  output logic                            full,
  input  logic                            action_i,
  input  logic [9:0]                      adc_sample_i,
  // result queue side
  output logic                            empty,
  input  logic                            pop,
  output logic [9:0]                      duty_o,
  output logic [23:0]                     measured_rpm_o,
  output logic                            integral_clamped_o,
  output logic                            output_clamped_o,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [psc_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [psc_pkg::CfgDataBits-1:0] cfg_data_i
);

  psc_pkg::cfg_t cfg_q, cfg_d;

  logic                   tick_valid, tick_pop;
  logic [CounterBits-1:0] tick_cnt;
  logic [9:0]             tick_adc;
  logic                   res_full, res_push;
  psc_pkg::result_t       res_wr, res_rd;

  // configuration registers, masked to their widths
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psc_pkg::RegReferenceRpm:  cfg_d.reference_rpm  = cfg_data_i;
        psc_pkg::RegPropGain:      cfg_d.prop_gain      = cfg_data_i;
        psc_pkg::RegIntGainDt:     cfg_d.int_gain_dt    = cfg_data_i;
        psc_pkg::RegIntegralLimit: cfg_d.integral_limit = cfg_data_i[9:0];
        psc_pkg::RegDutyMax:       cfg_d.duty_max       = cfg_data_i[9:0];
        psc_pkg::RegRpmPerCount:   cfg_d.rpm_per_count  = cfg_data_i;
        psc_pkg::RegFineTuneSpan:  cfg_d.fine_tune_span = cfg_data_i;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reference_rpm  <= psc_pkg::ReferenceRpmRst;
      cfg_q.prop_gain      <= psc_pkg::PropGainRst;
      cfg_q.int_gain_dt    <= psc_pkg::IntGainDtRst;
      cfg_q.integral_limit <= psc_pkg::IntegralLimitRst;
      cfg_q.duty_max       <= psc_pkg::DutyMaxRst;
      cfg_q.rpm_per_count  <= psc_pkg::RpmPerCountRst;
      cfg_q.fine_tune_span <= psc_pkg::FineTuneSpanRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // edge counting and tick queue
  psc_front #(
    .CounterBits(CounterBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .action_i    (action_i),
    .adc_sample_i(adc_sample_i),
    .full_o      (full),
    .tick_pop_i  (tick_pop),
    .tick_valid_o(tick_valid),
    .tick_cnt_o  (tick_cnt),
    .tick_adc_o  (tick_adc)
  );

  // pi step sequencer
  psc_back #(
    .CounterBits(CounterBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .tick_valid_i(tick_valid),
    .tick_cnt_i  (tick_cnt),
    .tick_adc_i  (tick_adc),
    .tick_pop_o  (tick_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_wr)
  );

  // result queue toward the consumer
  psc_fifo #(
    .Width($bits(psc_pkg::result_t))
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_wr),
    .pop_i  (pop),
    .full_o (res_full),
    .empty_o(empty),
    .rdata_o(res_rd)
  );

  assign duty_o             = res_rd.duty;
  assign measured_rpm_o     = res_rd.measured_rpm;
  assign integral_clamped_o = res_rd.integral_clamped;
  assign output_clamped_o   = res_rd.output_clamped;

endmodule
